// ----- rtl/sbm_pkg.sv -----
`default_nettype none
package sbm_pkg;
	localparam int ENTRIES       = 32;
	localparam int PATTERN_BYTES = 32;

	localparam logic [1:0] KIND_PAT    = 2'd0;
	localparam logic [1:0] KIND_ATTR   = 2'd1;
	localparam logic [1:0] KIND_TARGET = 2'd2;
	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam logic [1:0] MT_EXACT    = 2'd0;
	localparam logic [1:0] MT_PREFIX   = 2'd1;
	localparam logic [1:0] MT_OFF      = 2'd3;
	localparam logic [7:0] BLOCK_LEVEL = 8'd2;

	localparam logic [0:0] REG_ENFORCE = 1'd0;
	localparam logic [0:0] REG_LOG_ALL = 1'd1;

	typedef struct packed {
		logic [1:0] kind;
		logic [4:0] entry_index;
		logic [4:0] char_pos;
		logic [7:0] char_value;
		logic [1:0] cmp_mode;
		logic [7:0] severity_in;
		logic       entry_enable;
		logic       last;
	} item_t;
endpackage
`default_nettype wire

// ----- rtl/sbm_front.sv -----
`default_nettype none
// Two-deep queue toward the back end; unused-kind items are dropped here.
module sbm_front (
	input  wire           clk,
	input  wire           arst_n,
	input  wire           in_valid,
	output logic          in_stall,
	input  sbm_pkg::item_t in_item,
	output logic          q_valid,
	input  wire           q_take,
	output sbm_pkg::item_t q_item
);
	import sbm_pkg::*;
	item_t  mem_q [2];
	logic   wp_q, rp_q;
	logic [1:0] cnt_q;
	logic   push;

	assign in_stall = (cnt_q == 2'd2);
	assign push     = in_valid && !in_stall && (in_item.kind != KIND_UNUSED);
	assign q_valid  = (cnt_q != 2'd0);
	assign q_item   = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= in_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (q_take) rp_q <= !rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_take};
		end
	end
endmodule
`default_nettype wire

// ----- rtl/sbm_back.sv -----
`default_nettype none
// Pattern memory (one row per byte position, one byte lane per entry), attributes,
// per-entry running flags, NUL padding sweep and result register.
module sbm_back (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            q_valid,
	output logic           q_take,
	input  sbm_pkg::item_t q_item,
	input  wire            enforce_enabled,
	input  wire            log_all,
	output logic           out_valid,
	input  wire            out_stall,
	output logic           matched,
	output logic [4:0]     matched_entry,
	output logic [7:0]     severity,
	output logic           blocked,
	output logic           deny,
	output logic           log_event
);
	import sbm_pkg::*;
	localparam int EW = $clog2(ENTRIES);
	localparam int PW = $clog2(PATTERN_BYTES);
	localparam int PC = PW + 1;

	localparam logic [2:0] ST_CLR  = 3'd0;  // clearing pass after reset
	localparam logic [2:0] ST_IDLE = 3'd1;  // taking items
	localparam logic [2:0] ST_CMP  = 3'd2;  // compare read row against all entries
	localparam logic [2:0] ST_PAD  = 3'd3;  // read next row for NUL padding
	localparam logic [2:0] ST_RES  = 3'd4;  // form result once the output is free

	logic [ENTRIES*8-1:0] pat_mem [PATTERN_BYTES];
	logic [ENTRIES*8-1:0] rd_s1;
	logic [7:0]    tch_s1;
	logic          last_s1;
	logic [1:0]    type_q [ENTRIES];
	logic [7:0]    sev_q  [ENTRIES];
	logic [ENTRIES-1:0] en_q, nz_q, cmp_q, hit_q;
	logic [PC-1:0] pos_q;
	logic [PW-1:0] clr_q;
	logic [2:0]    st_q;
	logic          ov_q;

	logic          is_tgt, in_rng, rd_en, res_go;
	logic [PW-1:0] pidx;
	logic [ENTRIES-1:0] cmp_n, hit_n;
	logic          f_m;
	logic [EW-1:0] f_e;
	logic [7:0]    f_sev;

	assign q_take = q_valid && (st_q == ST_IDLE);
	assign is_tgt = q_item.kind == KIND_TARGET;
	assign in_rng = pos_q < PC'(PATTERN_BYTES);
	assign pidx   = pos_q[PW-1:0];
	assign rd_en  = (q_take && is_tgt && in_rng) || (st_q == ST_PAD);
	assign res_go = (st_q == ST_RES) && (!ov_q || !out_stall);
	assign f_sev  = sev_q[f_e];

	always_ff @(posedge clk) begin
		if (st_q == ST_CLR)
			pat_mem[clr_q] <= '0;
		else if (q_take && q_item.kind == KIND_PAT)
			pat_mem[q_item.char_pos][{q_item.entry_index, 3'b000} +: 8] <= q_item.char_value;
		if (rd_en) rd_s1 <= pat_mem[pidx];
	end

	always_comb begin
		cmp_n = cmp_q;
		hit_n = hit_q;
		for (int e = 0; e < ENTRIES; e++) begin
			if (cmp_q[e]) begin
				case (type_q[e])
					MT_EXACT: begin
						if (tch_s1 != rd_s1[e*8 +: 8]) cmp_n[e] = 1'b0;
						else if (tch_s1 == 8'd0 || pidx == PW'(PATTERN_BYTES-1)) begin
							hit_n[e] = 1'b1;
							cmp_n[e] = 1'b0;
						end
					end
					MT_PREFIX: begin
						if (rd_s1[e*8 +: 8] == 8'd0) begin
							hit_n[e] = 1'b1;
							cmp_n[e] = 1'b0;
						end else if (tch_s1 != rd_s1[e*8 +: 8] ||
						             pidx == PW'(PATTERN_BYTES-1))
							cmp_n[e] = 1'b0;
					end
					default: cmp_n[e] = 1'b0;
				endcase
			end
		end
	end

	// lowest enabled, non-empty entry that hit
	always_comb begin
		f_m = 1'b0;
		f_e = '0;
		for (int e = ENTRIES-1; e >= 0; e--) begin
			if (en_q[e] && nz_q[e] && hit_q[e]) begin
				f_m = 1'b1;
				f_e = EW'(e);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int e = 0; e < ENTRIES; e++) begin
				type_q[e] <= 2'd0; sev_q[e] <= 8'd0;
			end
			en_q <= '0; nz_q <= '0; cmp_q <= '1; hit_q <= '0; pos_q <= '0;
			clr_q <= '0; st_q <= ST_CLR; ov_q <= 1'b0;
			tch_s1 <= 8'd0; last_s1 <= 1'b0;
			matched <= 1'b0; matched_entry <= '0; severity <= '0;
			blocked <= 1'b0; deny <= 1'b0; log_event <= 1'b0;
		end else begin
			ov_q <= res_go || (ov_q && out_stall);
			case (st_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == PW'(PATTERN_BYTES-1)) st_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (q_take) begin
						case (q_item.kind)
							KIND_PAT: begin
								if (q_item.char_pos == '0)
									nz_q[q_item.entry_index] <= (q_item.char_value != 8'd0);
							end
							KIND_ATTR: begin
								type_q[q_item.entry_index] <= q_item.cmp_mode;
								sev_q[q_item.entry_index]  <= q_item.severity_in;
								en_q[q_item.entry_index]   <= q_item.entry_enable;
							end
							KIND_TARGET: begin
								tch_s1  <= q_item.char_value;
								last_s1 <= q_item.last;
								if (in_rng) st_q <= ST_CMP;
								else if (q_item.last) st_q <= ST_RES;
							end
							default: ;
						endcase
					end
				end
				ST_CMP: begin
					cmp_q <= cmp_n; hit_q <= hit_n; pos_q <= pos_q + 1'b1;
					if (!last_s1) st_q <= ST_IDLE;
					else if (pos_q == PC'(PATTERN_BYTES-1)) st_q <= ST_RES;
					else begin
						st_q   <= ST_PAD;
						tch_s1 <= 8'd0;
					end
				end
				ST_PAD: st_q <= ST_CMP;
				ST_RES: begin
					if (res_go) begin
						st_q <= ST_IDLE;
						matched <= f_m;
						matched_entry <= f_e;
						severity <= f_m ? f_sev : 8'd0;
						blocked <= f_m && f_sev >= BLOCK_LEVEL;
						deny <= f_m && f_sev >= BLOCK_LEVEL && enforce_enabled;
						log_event <= (f_m && f_sev != 8'd0) || log_all;
						cmp_q <= '1; hit_q <= '0; pos_q <= '0;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end
	assign out_valid = ov_q;
endmodule
`default_nettype wire

// ----- rtl/string_blacklist_matcher_unit.sv -----
`default_nettype none
// After reset the back end clears the pattern memory row by row; the queue still fills.
// Loads: each is applied when the idle back end takes it from the queue.
// Target byte within the first 32: registered row read, then compare against all entries.
// Last byte: compare, then a row read and compare for each NUL-padded position, then the result register;
// a target that already ran past 32 bytes goes straight to the result; output stall holds the result.
// Async reset clears flags, attributes, queue and config (enforce=1, log_all=0).
module string_blacklist_matcher_unit (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	output logic       in_stall,
	input  wire [1:0]  kind,
	input  wire [4:0]  entry_index,
	input  wire [4:0]  char_pos,
	input  wire [7:0]  char_value,
	input  wire [1:0]  cmp_mode,
	input  wire [7:0]  severity_in,
	input  wire        entry_enable,
	input  wire        last,
	output logic       out_valid,
	input  wire        out_stall,
	output logic       matched,
	output logic [4:0] matched_entry,
	output logic [7:0] severity,
	output logic       blocked,
	output logic       deny,
	output logic       log_event,
	input  wire        cfg_we,
	input  wire [0:0]  cfg_index,
	input  wire [0:0]  cfg_data
);
	import sbm_pkg::*;
	item_t in_item, q_item;
	logic  q_valid, q_take;
	logic  enforce_q, log_all_q;

	assign in_item = '{kind: kind, entry_index: entry_index, char_pos: char_pos,
		char_value: char_value, cmp_mode: cmp_mode, severity_in: severity_in,
		entry_enable: entry_enable, last: last};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enforce_q <= 1'b1; log_all_q <= 1'b0;
		end else if (cfg_we) begin
			if (cfg_index == REG_ENFORCE) enforce_q <= cfg_data[0];
			else log_all_q <= cfg_data[0];
		end
	end

	sbm_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.in_item(in_item), .q_valid(q_valid), .q_take(q_take), .q_item(q_item)
	);

	sbm_back u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_take(q_take),
		.q_item(q_item), .enforce_enabled(enforce_q), .log_all(log_all_q),
		.out_valid(out_valid), .out_stall(out_stall), .matched(matched),
		.matched_entry(matched_entry), .severity(severity), .blocked(blocked),
		.deny(deny), .log_event(log_event)
	);
endmodule
`default_nettype wire
